// ===== rtl/core/evw_pkg.sv =====
// Shared types and constants for the energy VAD window decision block.
package evw_pkg;

    localparam int ENERGY_BITS    = 16;
    localparam int SUM_BITS       = 48;
    localparam int NUM_BITS       = SUM_BITS + 8;
    localparam int THR_BITS       = NUM_BITS + 1;
    localparam int THRESH_BITS    = 16;
    localparam int SCALE_BITS     = 8;
    localparam int PROP_BITS      = 9;
    localparam int CTX_BITS       = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int MAX_RESULTS    = 8;
    localparam int PEND_BITS      = 4;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd1280;
    localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 8'd128;
    localparam logic [PROP_BITS-1:0]   PROP_RESET   = 9'd154;
    localparam logic [CTX_BITS-1:0]    CTX_RESET    = 4'd2;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_MEAN_SCALE = 2'd1,
        CFG_PROPORTION = 2'd2,
        CFG_CONTEXT    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                          cmd;
        logic signed [ENERGY_BITS-1:0] frame_energy;
    } frame_req_t;

    typedef struct packed {
        logic                          is_speech;
        logic signed [ENERGY_BITS-1:0] decided_energy;
        logic                          last;
    } vad_result_t;

    typedef struct packed {
        logic done;
        logic rem_nonzero;
    } div_status_t;

endpackage

// ===== rtl/core/evw_cell.sv =====
// One window cell: holds one energy, takes it from the newer or older neighbor.
module evw_cell
    import evw_pkg::*;
(
    input  logic                          clk,
    input  logic                          push,
    input  logic                          rotate,
    input  logic signed [ENERGY_BITS-1:0] newer,
    input  logic signed [ENERGY_BITS-1:0] older,
    output logic signed [ENERGY_BITS-1:0] energy
);

    logic signed [ENERGY_BITS-1:0] energy_reg;

    always_ff @(posedge clk)
    begin
        priority if (push)
        begin
            energy_reg <= newer;
        end
        else if (rotate)
        begin
            energy_reg <= older;
        end
        else
        begin
            // hold
            energy_reg <= energy_reg;
        end
    end

    assign energy = energy_reg;

endmodule

// ===== rtl/core/evw_div.sv =====
// Restoring divider, one quotient bit per cycle.
module evw_div
    import evw_pkg::*;
#(
    parameter int DIVISOR_BITS = 40
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_BITS-1:0]     dividend,
    input  logic [DIVISOR_BITS-1:0] divisor,
    output logic [NUM_BITS-1:0]     quotient,
    output div_status_t             status
);

    localparam int STEP_BITS = $clog2(NUM_BITS);

    logic [NUM_BITS-1:0]     quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   trial_diff;
    logic                    fits;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[NUM_BITS-1]};
        trial_diff = trial - {1'b0, divisor};
        fits       = trial >= {1'b0, divisor};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            quo_next  = {quo_reg[NUM_BITS-2:0], fits};
            rem_next  = fits ? trial_diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_BITS'(NUM_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient           = quo_reg;
    assign status.done        = done_reg;
    assign status.rem_nonzero = |rem_reg;

endmodule

// ===== rtl/core/energy_vad_window_decision.sv =====
// Top level of the energy VAD window decision block.
//
// Energy VAD window decision. Each request on the frame channel is either a
// new Q8.8 log energy or a flush. A new energy is added to the saturating
// segment sum and count and pushed into a ring of 2*MAX_CONTEXT+1 cells;
// once more than W frames are held (W = context_frames, limited to
// MAX_CONTEXT) it yields one decision for the frame W back. A flush yields
// up to min(W, 8) decisions for the trailing frames, each over a window
// clipped at the oldest held frame, and then clears the segment. A frame
// that yields a decision passes through these steps before its result is
// loaded into the output register: the sum*scale product, the divider
// launch, the serial mean divider that produces one quotient bit a cycle,
// the ring scan that counts energies above threshold at one cell per
// cycle, and the load of the result, which waits for a free output
// register. A flush reuses its threshold, so every further decision of the
// run adds only another ring scan and load. The frame channel stalls while
// a request is in progress; a finished result may sit in the output
// register while the next request is taken. Configuration writes are
// always ready and must only be made while the block is idle.
module energy_vad_window_decision
    import evw_pkg::*;
#(
    parameter int MAX_CONTEXT = 8,
    parameter int COUNT_BITS  = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      frame_valid,
    output logic                      frame_stall,
    input  frame_req_t                frame,
    output logic                      vad_valid,
    input  logic                      vad_stall,
    output vad_result_t               vad,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int DEPTH        = 2 * MAX_CONTEXT + 1;
    localparam int USED_BITS    = $clog2(DEPTH + 1);
    localparam int AGE_BITS     = $clog2(DEPTH);
    localparam int DIVISOR_BITS = COUNT_BITS + 8;
    localparam int PW           = USED_BITS + PROP_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // configuration registers
    logic signed [THRESH_BITS-1:0] thresh_reg;
    logic [SCALE_BITS-1:0]         scale_reg;
    logic [PROP_BITS-1:0]          prop_reg;
    logic [CTX_BITS-1:0]           ctx_reg;

    // control and segment state
    state_t                     state_reg, state_next;
    logic [USED_BITS-1:0]       used_reg, used_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [COUNT_BITS-1:0]      frames_reg, frames_next;
    logic [COUNT_BITS-1:0]      dec_reg, dec_next;
    logic                       flush_reg, flush_next;
    logic [AGE_BITS-1:0]        age_reg, age_next;
    logic [AGE_BITS-1:0]        lim_reg, lim_next;
    logic [AGE_BITS-1:0]        step_reg, step_next;
    logic [USED_BITS-1:0]       hits_reg, hits_next;
    logic signed [ENERGY_BITS-1:0] pick_reg, pick_next;
    logic signed [NUM_BITS:0]   prod_reg, prod_next;
    logic signed [THR_BITS-1:0] thr_reg, thr_next;
    logic                       out_valid_reg, out_valid_next;
    vad_result_t                out_reg, out_next;

    // datapath helpers
    logic [CTX_BITS-1:0]           half_win;
    logic signed [ENERGY_BITS-1:0] energy_in;
    logic signed [SUM_BITS:0]      sum_wide;
    logic signed [SUM_BITS-1:0]    sum_sat;
    logic [COUNT_BITS-1:0]         frames_inc;
    logic [COUNT_BITS-1:0]         dec_inc;
    logic [USED_BITS-1:0]          cap;
    logic [USED_BITS-1:0]          used_push;
    logic                          decide_now;
    logic [COUNT_BITS-1:0]         pend_diff;
    logic [USED_BITS-1:0]          pend_m1;
    logic [USED_BITS-1:0]          pend_m2;
    logic [PEND_BITS-1:0]          pend;
    logic [AGE_BITS-1:0]           first_age;
    logic [AGE_BITS-1:0]           lim_first;
    logic [AGE_BITS-1:0]           lim_step;
    logic [USED_BITS-1:0]          used_top;
    logic [USED_BITS-1:0]          cand_first;
    logic [USED_BITS-1:0]          cand_step;
    logic [NUM_BITS-1:0]           prod_mag;
    logic signed [THR_BITS-1:0]    quo_s;
    logic signed [THR_BITS-1:0]    quo_adj;
    logic                          above;
    logic [USED_BITS-1:0]          den;
    logic [PW-1:0]                 lhs;
    logic [PW-1:0]                 rhs;
    logic                          speech;
    logic                          out_free;
    logic                          push_en;
    logic                          rot_en;

    // window ring
    logic signed [ENERGY_BITS-1:0] cell_q [DEPTH];
    logic signed [ENERGY_BITS-1:0] newer_in [DEPTH];
    logic signed [ENERGY_BITS-1:0] older_in [DEPTH];

    // divider
    logic                    div_start;
    logic [DIVISOR_BITS-1:0] div_divisor;
    logic [NUM_BITS-1:0]     div_quo;
    div_status_t             div_stat;

    // --------------------------------------------------------------------
    // Configuration port: always ready, masked to each register's width.
    // --------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            scale_reg  <= SCALE_RESET;
            prop_reg   <= PROP_RESET;
            ctx_reg    <= CTX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_THRESHOLD:  thresh_reg <= cfg_data[THRESH_BITS-1:0];
                CFG_MEAN_SCALE: scale_reg  <= cfg_data[SCALE_BITS-1:0];
                CFG_PROPORTION: prop_reg   <= cfg_data[PROP_BITS-1:0];
                CFG_CONTEXT:    ctx_reg    <= cfg_data[CTX_BITS-1:0];
            endcase
        end
    end

    // --------------------------------------------------------------------
    // Frame bookkeeping: saturating sum and counts, ring fill level.
    // --------------------------------------------------------------------
    assign half_win  = (32'(ctx_reg) > MAX_CONTEXT) ? CTX_BITS'(MAX_CONTEXT) : ctx_reg;
    assign energy_in = frame.frame_energy;

    always_comb
    begin
        sum_wide = (SUM_BITS + 1)'(sum_reg) + (SUM_BITS + 1)'(energy_in);
        // clamp to the signed sum range on overflow
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
        begin
            sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                                         : {1'b0, {(SUM_BITS - 1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_BITS-1:0];
        end
    end

    assign frames_inc = (&frames_reg) ? frames_reg : frames_reg + 1'b1;
    assign dec_inc    = (&dec_reg) ? dec_reg : dec_reg + 1'b1;

    // a full window drops its oldest entries, so the fill just caps at 2W+1
    assign cap        = USED_BITS'({half_win, 1'b1});
    assign used_push  = (used_reg >= cap) ? cap : used_reg + 1'b1;
    assign decide_now = used_push > USED_BITS'(half_win);

    // --------------------------------------------------------------------
    // Flush: number of trailing frames still owed a decision.
    // --------------------------------------------------------------------
    assign pend_diff = (frames_reg >= dec_reg) ? frames_reg - dec_reg : '0;
    assign pend_m1   = (used_reg < USED_BITS'(half_win)) ? used_reg : USED_BITS'(half_win);
    assign pend_m2   = (pend_diff < COUNT_BITS'(pend_m1)) ? USED_BITS'(pend_diff) : pend_m1;
    assign pend      = (32'(pend_m2) > MAX_RESULTS) ? PEND_BITS'(MAX_RESULTS)
                                                    : PEND_BITS'(pend_m2);
    assign first_age = AGE_BITS'(pend - 1'b1);

    // oldest age counted for a flush decision at age a: min(used-1, a+W)
    assign used_top   = used_reg - 1'b1;
    assign cand_first = USED_BITS'(first_age) + USED_BITS'(half_win);
    assign cand_step  = USED_BITS'(age_reg - 1'b1) + USED_BITS'(half_win);
    assign lim_first  = AGE_BITS'((cand_first < used_top) ? cand_first : used_top);
    assign lim_step   = AGE_BITS'((cand_step < used_top) ? cand_step : used_top);

    // --------------------------------------------------------------------
    // Threshold: energy_threshold + floor(sum*scale / (frames*256)).
    // --------------------------------------------------------------------
    assign prod_mag    = prod_reg[NUM_BITS] ? NUM_BITS'(-prod_reg) : NUM_BITS'(prod_reg);
    assign div_start   = (state_reg == ST_DSTART);
    assign div_divisor = {frames_reg, 8'b0};

    evw_div #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .status   (div_stat)
    );

    // negative dividend: floor rounds down one more when a remainder is left
    assign quo_s   = $signed({1'b0, div_quo});
    assign quo_adj = prod_reg[NUM_BITS]
                   ? -quo_s - $signed({{(THR_BITS - 1){1'b0}}, div_stat.rem_nonzero})
                   : quo_s;

    // --------------------------------------------------------------------
    // Ring of cells. Push shifts toward older; during a scan the ring turns
    // toward newer, so cell 0 shows age k at scan step k and a full turn of
    // DEPTH steps restores the ring.
    // --------------------------------------------------------------------
    assign push_en = (state_reg == ST_IDLE) && frame_valid && (frame.cmd == CMD_FRAME);
    assign rot_en  = (state_reg == ST_SCAN);

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            assign newer_in[j] = energy_in;
        end
        else
        begin : g_body
            assign newer_in[j] = cell_q[j-1];
        end

        if (j == DEPTH - 1)
        begin : g_tail
            assign older_in[j] = cell_q[0];
        end
        else
        begin : g_inner
            assign older_in[j] = cell_q[j+1];
        end

        evw_cell u_cell (
            .clk    (clk),
            .push   (push_en),
            .rotate (rot_en),
            .newer  (newer_in[j]),
            .older  (older_in[j]),
            .energy (cell_q[j])
        );
    end

    assign above = THR_BITS'(cell_q[0]) > thr_reg;

    // speech when hits*256 >= frames_in_window*proportion
    assign den    = USED_BITS'(lim_reg) + 1'b1;
    assign lhs    = PW'({hits_reg, 8'b0});
    assign rhs    = PW'(den) * PW'(prop_reg);
    assign speech = lhs >= rhs;

    assign out_free = !out_valid_reg || !vad_stall;

    // --------------------------------------------------------------------
    // Sequencer
    // --------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        sum_next       = sum_reg;
        frames_next    = frames_reg;
        dec_next       = dec_reg;
        flush_next     = flush_reg;
        age_next       = age_reg;
        lim_next       = lim_reg;
        step_next      = step_reg;
        hits_next      = hits_reg;
        pick_next      = pick_reg;
        prod_next      = prod_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg && vad_stall;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    unique case (frame.cmd)
                        CMD_FRAME:
                        begin
                            sum_next    = sum_sat;
                            frames_next = frames_inc;
                            used_next   = used_push;
                            if (decide_now)
                            begin
                                // decide the frame W back over the whole window
                                dec_next   = dec_inc;
                                flush_next = 1'b0;
                                age_next   = AGE_BITS'(half_win);
                                lim_next   = AGE_BITS'(used_push - 1'b1);
                                state_next = ST_MUL;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            if (pend == '0)
                            begin
                                // nothing owed: drop the segment right away
                                used_next   = '0;
                                sum_next    = '0;
                                frames_next = '0;
                                dec_next    = '0;
                            end
                            else
                            begin
                                flush_next = 1'b1;
                                age_next   = first_age;
                                lim_next   = lim_first;
                                state_next = ST_MUL;
                            end
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                prod_next  = (NUM_BITS + 1)'(sum_reg) * (NUM_BITS + 1)'($signed({1'b0, scale_reg}));
                state_next = ST_DSTART;
            end

            ST_DSTART:
            begin
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    thr_next   = THR_BITS'(thresh_reg) + quo_adj;
                    step_next  = '0;
                    hits_next  = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if ((step_reg <= lim_reg) && above)
                begin
                    hits_next = hits_reg + 1'b1;
                end
                if (step_reg == age_reg)
                begin
                    pick_next = cell_q[0];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == AGE_BITS'(DEPTH - 1))
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.is_speech      = speech;
                    out_next.decided_energy = pick_reg;
                    out_next.last           = !flush_reg || (age_reg == '0);
                    if (flush_reg && (age_reg != '0))
                    begin
                        // advance to the next newer pending frame
                        age_next   = age_reg - 1'b1;
                        lim_next   = lim_step;
                        step_next  = '0;
                        hits_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        if (flush_reg)
                        begin
                            used_next   = '0;
                            sum_next    = '0;
                            frames_next = '0;
                            dec_next    = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            sum_reg       <= '0;
            frames_reg    <= '0;
            dec_reg       <= '0;
            flush_reg     <= 1'b0;
            age_reg       <= '0;
            lim_reg       <= '0;
            step_reg      <= '0;
            hits_reg      <= '0;
            pick_reg      <= '0;
            prod_reg      <= '0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            sum_reg       <= sum_next;
            frames_reg    <= frames_next;
            dec_reg       <= dec_next;
            flush_reg     <= flush_next;
            age_reg       <= age_next;
            lim_reg       <= lim_next;
            step_reg      <= step_next;
            hits_reg      <= hits_next;
            pick_reg      <= pick_next;
            prod_reg      <= prod_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // hold the frame channel while a request is in progress
    assign frame_stall = (state_reg != ST_IDLE);
    assign vad_valid   = out_valid_reg;
    assign vad         = out_reg;

`ifndef NO_ASSERTIONS
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared outside the emit step");

    a_dec_le_frames: assert property (@(posedge clk) disable iff (!rst_n)
        dec_reg <= frames_reg)
        else $error("more decisions than frames");

    a_scan_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (USED_BITS'(lim_reg) < used_reg))
        else $error("scan limit beyond held frames");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && !flush_reg) |=> (vad_valid && vad.last))
        else $error("single frame decision without last");
`endif

endmodule

// ===== tb/evw_decision_checker.sv =====
// Checker for the energy VAD block: tracks segment state, predicts decisions, compares results.
`timescale 1ns / 100ps

module evw_decision_checker
    import evw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      frame_valid,
    input  logic                      frame_stall,
    input  frame_req_t                frame,
    input  logic                      vad_valid,
    input  logic                      vad_stall,
    input  vad_result_t               vad,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        pending_results,
    output int                        mismatches
);

    localparam int          CONTEXT_CAP = 8;
    localparam int          HIST_DEPTH  = 2 * CONTEXT_CAP + 1;
    localparam longint      SUM_HI      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      SUM_LO      = -SUM_HI - 1;
    localparam logic [31:0] COUNT_TOP   = 32'hFFFF_FFFF;
    localparam int          REPORT_MAX  = 10;

    // segment state
    logic signed [ENERGY_BITS-1:0] hist [HIST_DEPTH];
    int unsigned                   hist_used;
    longint                        seg_sum;
    logic [31:0]                   frames_in;
    logic [31:0]                   decided;

    // register copies
    logic signed [THRESH_BITS-1:0] base_thr;
    logic [SCALE_BITS-1:0]         scale;
    logic [PROP_BITS-1:0]          prop;
    logic [CTX_BITS-1:0]           ctx;

    vad_result_t decisions_due [$];

    function automatic int unsigned half_win();
        return (ctx > CTX_BITS'(CONTEXT_CAP)) ? CONTEXT_CAP : int'(ctx);
    endfunction

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // threshold plus scaled segment mean, floored
    function automatic longint live_threshold();
        longint den;
        den = longint'(frames_in) * 256;
        if (den == 0)
            return longint'(base_thr);
        return longint'(base_thr) + floor_quot(seg_sum * longint'(scale), den);
    endfunction

    function automatic logic speech_vote(int unsigned lo, longint thr);
        int unsigned i;
        int unsigned above;
        int unsigned held;
        above = 0;
        held  = 0;
        for (i = lo; i < hist_used; i++)
        begin
            held++;
            if (longint'(hist[i]) > thr)
                above++;
        end
        return (above * 256) >= (held * int'(prop));
    endfunction

    function automatic void shift_in(logic signed [ENERGY_BITS-1:0] e, int unsigned w);
        int unsigned cap;
        int unsigned drop;
        int unsigned i;
        cap = 2 * w + 1;
        if (hist_used >= cap)
        begin
            drop = hist_used - cap + 1;
            for (i = 0; i < hist_used - drop; i++)
                hist[i] = hist[i + drop];
            hist_used -= drop;
        end
        hist[hist_used] = e;
        hist_used++;
    endfunction

    function automatic void clear_segment();
        hist_used = 0;
        seg_sum   = 0;
        frames_in = '0;
        decided   = '0;
    endfunction

    function automatic void predict_decisions(frame_req_t req);
        int unsigned w;
        int unsigned pend;
        int unsigned i;
        int unsigned p;
        int unsigned lo;
        longint      thr;
        vad_result_t r;
        w = half_win();
        if (req.cmd == CMD_FRAME)
        begin
            seg_sum = seg_sum + longint'(req.frame_energy);
            if (seg_sum > SUM_HI)
                seg_sum = SUM_HI;
            if (seg_sum < SUM_LO)
                seg_sum = SUM_LO;
            if (frames_in != COUNT_TOP)
                frames_in++;
            shift_in(req.frame_energy, w);
            if (hist_used > w)
            begin
                thr = live_threshold();
                r.is_speech      = speech_vote(0, thr);
                r.decided_energy = hist[hist_used - (w + 1)];
                r.last           = 1'b1;
                if (decided != COUNT_TOP)
                    decided++;
                decisions_due.push_back(r);
            end
        end
        else
        begin
            pend = (frames_in >= decided) ? int'(frames_in - decided) : 0;
            if (pend > hist_used)
                pend = hist_used;
            if (pend > w)
                pend = w;
            if (pend > MAX_RESULTS)
                pend = MAX_RESULTS;
            thr = live_threshold();
            for (i = 0; i < pend; i++)
            begin
                p  = hist_used - pend + i;
                lo = (p >= w) ? p - w : 0;
                r.is_speech      = speech_vote(lo, thr);
                r.decided_energy = hist[p];
                r.last           = (i + 1 == pend);
                decisions_due.push_back(r);
            end
            clear_segment();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vad_result_t want;
        if (!rst_n)
        begin
            clear_segment();
            base_thr = THRESH_RESET;
            scale    = SCALE_RESET;
            prop     = PROP_RESET;
            ctx      = CTX_RESET;
            decisions_due.delete();
            pending_results = 0;
            mismatches      = 0;
        end
        else
        begin
            // compare first: a result never belongs to a request taken at the same edge
            if (vad_valid && !vad_stall)
            begin
                if (decisions_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("vad result with nothing due: speech=%0d energy=%0d last=%0d",
                                 vad.is_speech, vad.decided_energy, vad.last);
                end
                else
                begin
                    want = decisions_due.pop_front();
                    if (vad.is_speech !== want.is_speech
                        || vad.decided_energy !== want.decided_energy
                        || vad.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"vad result error: expected speech=%0d energy=%0d ",
                                      "last=%0d, got speech=%0d energy=%0d last=%0d"},
                                     want.is_speech, want.decided_energy, want.last,
                                     vad.is_speech, vad.decided_energy, vad.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_THRESHOLD:  base_thr = cfg_data[THRESH_BITS-1:0];
                    CFG_MEAN_SCALE: scale    = cfg_data[SCALE_BITS-1:0];
                    CFG_PROPORTION: prop     = cfg_data[PROP_BITS-1:0];
                    CFG_CONTEXT:    ctx      = cfg_data[CTX_BITS-1:0];
                    default:        ;
                endcase
            end
            if (frame_valid && !frame_stall)
                predict_decisions(frame);
            pending_results = decisions_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the energy VAD testbench: clock, reset, request stimulus, stalls and verdict.
`timescale 1ns / 100ps

module testbench;
    import evw_pkg::*;

    // Quiet time after the last result before a register write or the verdict.
    // An empty flush or a frame without a decision finishes far sooner than a
    // full flush run, so this covers any tail work.
    localparam int SETTLE_CYCLES = 300;
    // Slowest run: ~115 requests, each up to a full flush run plus idling and
    // stall per result, plus settle pauses. Take the sum several times over.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 14;

    logic                      clk;
    logic                      rst_n;
    logic                      frame_valid;
    logic                      frame_stall;
    frame_req_t                frame;
    logic                      vad_valid;
    logic                      vad_stall;
    vad_result_t               vad;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int pending_results;
    int mismatches;
    int cycle_count;

    // 0 disables idling on both sides; n gives roughly a 1-in-n chance of a burst
    int idle_odds;
    // last threshold written, used to aim energies near the decision edge
    logic signed [THRESH_BITS-1:0] thr_setting;

    energy_vad_window_decision dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .vad_valid   (vad_valid),
        .vad_stall   (vad_stall),
        .vad         (vad),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    evw_decision_checker decision_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_valid     (frame_valid),
        .frame_stall     (frame_stall),
        .frame           (frame),
        .vad_valid       (vad_valid),
        .vad_stall       (vad_stall),
        .vad             (vad),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .mismatches      (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if it hangs.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side back-pressure: raise stall in random bursts.
    // Lower and raise always fall on different edges.
    initial
    begin
        vad_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                vad_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                vad_stall <= 1'b0;
            end
        end
    end

    // Pick an energy: extremes, anything, or close to the base threshold.
    function automatic logic signed [ENERGY_BITS-1:0] pick_energy();
        int v;
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return ENERGY_BITS'($urandom);
            default:
            begin
                v = int'(thr_setting) + int'($urandom_range(0, 1024)) - 512;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                return ENERGY_BITS'(v);
            end
        endcase
    endfunction

    // Offer one request and hold it until the block takes it. Valid stays high
    // on return so that back-to-back requests never lower and raise it at once.
    task automatic send_request(input logic op, input logic signed [ENERGY_BITS-1:0] e);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= '{cmd: op, frame_energy: e};
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
    endtask

    // Drop valid, wait for every predicted decision, then let tail work finish.
    task automatic drain_results();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; only call while the block is idle.
    // Bits above each register's width carry junk that the block must drop.
    task automatic load_settings(input logic signed [THRESH_BITS-1:0] thr,
                                 input logic [SCALE_BITS-1:0] scl,
                                 input logic [PROP_BITS-1:0] prp,
                                 input logic [CTX_BITS-1:0] half);
        cfg_reg_t                 idx;
        logic [CFG_DATA_BITS-1:0] junk;
        logic [CFG_DATA_BITS-1:0] value;
        for (int k = 0; k < 4; k++)
        begin
            idx  = cfg_reg_t'(k);
            junk = CFG_DATA_BITS'($urandom);
            case (idx)
                CFG_THRESHOLD:  value = thr;
                CFG_MEAN_SCALE: value = {junk[CFG_DATA_BITS-1:SCALE_BITS], scl};
                CFG_PROPORTION: value = {junk[CFG_DATA_BITS-1:PROP_BITS], prp};
                default:        value = {junk[CFG_DATA_BITS-1:CTX_BITS], half};
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid   <= 1'b0;
        thr_setting = thr;
    endtask

    // Random traffic: mostly runs of frames closed by a flush, some lone
    // flushes as noise. Short runs leave fewer pending frames than W.
    task automatic run_phase(input bit close_segment);
        int sent;
        int run_len;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(CMD_FLUSH, ENERGY_BITS'($urandom));
                sent++;
            end
            else
            begin
                run_len = $urandom_range(1, 20);
                // keep the phase near its request budget
                if (run_len > PHASE_ITEMS - sent)
                    run_len = PHASE_ITEMS - sent;
                repeat (run_len)
                begin
                    send_request(CMD_FRAME, pick_energy());
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    send_request(CMD_FLUSH, ENERGY_BITS'($urandom));
                    sent++;
                end
            end
        end
        if (close_segment)
            send_request(CMD_FLUSH, ENERGY_BITS'($urandom));
        drain_results();
    endtask

    initial
    begin
        // hold every input at a known value from time zero
        rst_n       <= 1'b0;
        frame_valid <= 1'b0;
        frame       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_THRESHOLD;
        cfg_data    <= '0;
        idle_odds   = 3;
        thr_setting = THRESH_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings (W = 2).
        // Flush with nothing held: no decision, state cleared.
        send_request(CMD_FLUSH, 16'sh0000);
        // One frame then flush: a single decision over a clipped window.
        send_request(CMD_FRAME, 16'sh7FFF);
        send_request(CMD_FLUSH, 16'shFFFF);
        // Field extremes and values on either side of the base threshold.
        send_request(CMD_FRAME, 16'sh8000);
        send_request(CMD_FRAME, 16'sh0000);
        send_request(CMD_FRAME, 16'sh7FFF);
        send_request(CMD_FRAME, 16'sh0500);
        send_request(CMD_FRAME, 16'sh0501);
        send_request(CMD_FRAME, 16'shFFFF);
        send_request(CMD_FRAME, 16'sh5555);
        send_request(CMD_FRAME, 16'shAAAA);
        // Flush with W frames pending: two trailing decisions.
        send_request(CMD_FLUSH, 16'sh5555);
        // Back-to-back flushes: the second one finds nothing.
        send_request(CMD_FLUSH, 16'shAAAA);
        send_request(CMD_FRAME, 16'sh0100);
        send_request(CMD_FRAME, 16'shFF00);
        send_request(CMD_FLUSH, 16'sh0000);
        drain_results();

        // W = 0: every frame decides itself.
        load_settings(16'sh8000, 8'd0, 9'd0, 4'd0);
        run_phase(1'b1);

        // Highest threshold and weight, full proportion and window; leave the
        // segment open so the next phase lowers W mid segment.
        idle_odds = 2;
        load_settings(16'sh7FFF, 8'd255, 9'd256, 4'd8);
        run_phase(1'b0);

        idle_odds = 4;
        load_settings(THRESH_BITS'($urandom), SCALE_BITS'($urandom),
                      PROP_BITS'($urandom_range(0, 256)), 4'd3);
        run_phase(1'b0);

        // Half window above the cap acts as the cap; a stretch with no idling.
        idle_odds = 0;
        load_settings(THRESH_BITS'($urandom), SCALE_BITS'($urandom),
                      PROP_BITS'($urandom_range(0, 256)), 4'd15);
        run_phase(1'b1);

        idle_odds = 3;
        load_settings(THRESH_BITS'($urandom), SCALE_BITS'($urandom),
                      PROP_BITS'($urandom_range(0, 256)),
                      CTX_BITS'($urandom_range(0, 15)));
        run_phase(1'($urandom_range(0, 1)));

        // Final part runs without idling on either side.
        idle_odds = 0;
        load_settings(THRESH_BITS'($urandom), SCALE_BITS'($urandom),
                      PROP_BITS'($urandom_range(0, 256)),
                      CTX_BITS'($urandom_range(1, 8)));
        run_phase(1'b1);

        if (mismatches == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== energy_vad_window_decision.f =====
rtl/core/evw_pkg.sv
rtl/core/evw_cell.sv
rtl/core/evw_div.sv
rtl/core/energy_vad_window_decision.sv
tb/evw_decision_checker.sv
tb/testbench.sv
